// ===== rtl/vcp_pkg.sv =====
package vcp_pkg;

   localparam int unsigned OFFSET_W = 10;
   localparam int unsigned LENGTH_W = 10;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CSR_IDX_W = 2;

   // control point opcodes
   localparam logic [BYTE_W-1:0] OP_DOWN        = 8'd0;
   localparam logic [BYTE_W-1:0] OP_UP          = 8'd1;
   localparam logic [BYTE_W-1:0] OP_UNMUTE_DOWN = 8'd2;
   localparam logic [BYTE_W-1:0] OP_UNMUTE_UP   = 8'd3;
   localparam logic [BYTE_W-1:0] OP_SET_ABS     = 8'd4;
   localparam logic [BYTE_W-1:0] OP_UNMUTE      = 8'd5;
   localparam logic [BYTE_W-1:0] OP_MUTE        = 8'd6;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_NOTIFY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAGS_NOTIFY = 2'd2;

   localparam logic [LENGTH_W-1:0] LEN_SHORT = 10'd2;
   localparam logic [LENGTH_W-1:0] LEN_LONG  = 10'd3;
   localparam logic [OFFSET_W-1:0] OFFSET_ZERO = '0;

   localparam logic [BYTE_W-1:0] VOL_MIN        = 8'd0;
   localparam logic [BYTE_W-1:0] VOL_MAX        = 8'd255;
   localparam logic [BYTE_W-1:0] VOL_RESET      = 8'd128;
   localparam logic [BYTE_W-1:0] STEP_RESET     = 8'd16;
   localparam logic [BYTE_W-1:0] FLAG_PERSISTED = 8'h01 << 0;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_LEN     = 2'd1,
      ST_BAD_COUNTER = 2'd2,
      ST_BAD_OPCODE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] step_size;
      logic              state_notify_enable;
      logic              flags_notify_enable;
   } cfg_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] write_offset;
      logic [LENGTH_W-1:0] write_length;
      logic [BYTE_W-1:0]   action;
      logic [BYTE_W-1:0]   counter_operand;
      logic [BYTE_W-1:0]   absolute_volume;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] volume_level;
      logic              mute_flag;
      logic [BYTE_W-1:0] change_count;
      logic [BYTE_W-1:0] flag_byte;
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] volume_now;
      logic              mute_now;
      logic [BYTE_W-1:0] counter_now;
      logic [BYTE_W-1:0] flags_now;
      logic              flags_notify;
      logic              state_notify;
   } rsp_type;

endpackage

// ===== rtl/vcp_csr.sv =====
module vcp_csr import vcp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STEP_SIZE:    cfg_in.step_size           = csr_wdata;
            CSR_STATE_NOTIFY: cfg_in.state_notify_enable = csr_wdata[0];
            CSR_FLAGS_NOTIFY: cfg_in.flags_notify_enable = csr_wdata[0];
            default:          cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size           <= STEP_RESET;
         cfg_ff.state_notify_enable <= 1'b0;
         cfg_ff.flags_notify_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/vcp_update.sv =====
module vcp_update import vcp_pkg::*; (
   input  req_type   req,
   input  state_type state,
   input  cfg_type   cfg,
   output state_type state_next,
   output rsp_type   rsp
);

   status_type        status;
   logic [BYTE_W:0]   raise_sum;
   logic [BYTE_W-1:0] vol_lower;
   logic [BYTE_W-1:0] vol_raise;
   logic              flags_written;

   always_comb begin
      raise_sum = {1'b0, state.volume_level} + {1'b0, cfg.step_size};
      vol_raise = raise_sum[BYTE_W] ? VOL_MAX : raise_sum[BYTE_W-1:0];
      vol_lower = (state.volume_level > cfg.step_size) ?
                  state.volume_level - cfg.step_size : VOL_MIN;
   end

   // checks in priority order; set absolute needs the long form
   always_comb begin
      if (req.write_offset != OFFSET_ZERO ||
          !(req.write_length inside {LEN_SHORT, LEN_LONG})) begin
         status = ST_BAD_LEN;
      end else if (req.counter_operand != state.change_count) begin
         status = ST_BAD_COUNTER;
      end else if (req.action > OP_MUTE) begin
         status = ST_BAD_OPCODE;
      end else if (req.action == OP_SET_ABS && req.write_length != LEN_LONG) begin
         status = ST_BAD_LEN;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      state_next    = state;
      flags_written = 1'b0;
      if (status == ST_OK) begin
         case (req.action)
            OP_DOWN:        state_next.volume_level = vol_lower;
            OP_UP:          state_next.volume_level = vol_raise;
            OP_UNMUTE_DOWN: begin
               state_next.volume_level = vol_lower;
               state_next.mute_flag    = 1'b0;
            end
            OP_UNMUTE_UP:   begin
               state_next.volume_level = vol_raise;
               state_next.mute_flag    = 1'b0;
            end
            OP_SET_ABS:     state_next.volume_level = req.absolute_volume;
            OP_UNMUTE:      state_next.mute_flag = 1'b0;
            default:        state_next.mute_flag = 1'b1;
         endcase
         if (req.action <= OP_SET_ABS) begin
            state_next.flag_byte = FLAG_PERSISTED;
            flags_written        = 1'b1;
         end
         state_next.change_count = state.change_count + 8'd1;
      end
   end

   always_comb begin
      rsp.status       = status;
      rsp.volume_now   = state_next.volume_level;
      rsp.mute_now     = state_next.mute_flag;
      rsp.counter_now  = state_next.change_count;
      rsp.flags_now    = state_next.flag_byte;
      rsp.flags_notify = flags_written && cfg.flags_notify_enable;
      rsp.state_notify = (status == ST_OK) && cfg.state_notify_enable;
   end

endmodule

// ===== rtl/volume_control_point.sv =====
// A req transaction loads into the input register at the accepting edge and moves into
// the result register, raising rsp_valid, once that register is empty or being drained.
// Throughput: one transaction per cycle while rsp_ready does not stall the result
// register; the state update is computed combinationally between the input register and the result register.
// Reset (synchronous, active high): volume 128, unmuted, change counter 0,
// flags 0, step size 16, both notify enables off, both pipeline stages empty.
module volume_control_point import vcp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   // control point write
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OFFSET_W-1:0]  req_write_offset,
   input  logic [LENGTH_W-1:0]  req_write_length,
   input  logic [BYTE_W-1:0]    req_action,
   input  logic [BYTE_W-1:0]    req_counter_operand,
   input  logic [BYTE_W-1:0]    req_absolute_volume,

   // result of the write
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [BYTE_W-1:0]    rsp_volume_now,
   output logic                 rsp_mute_now,
   output logic [BYTE_W-1:0]    rsp_counter_now,
   output logic [BYTE_W-1:0]    rsp_flags_now,
   output logic                 rsp_flags_notify,
   output logic                 rsp_state_notify,

   // configuration registers
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   cfg_type   cfg;

   // input register stage
   logic      in_valid_ff;
   req_type   in_req_ff;

   // result register stage
   logic      out_valid_ff;
   rsp_type   out_rsp_ff;

   // live control point state
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;

   logic      advance;

   vcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held transaction moves into the result register whenever that
   // register is empty or being drained this cycle. The state commits at the
   // same edge, so the next transaction sees the updated counter and volume.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff.write_offset    <= req_write_offset;
         in_req_ff.write_length    <= req_write_length;
         in_req_ff.action          <= req_action;
         in_req_ff.counter_operand <= req_counter_operand;
         in_req_ff.absolute_volume <= req_absolute_volume;
      end
   end

   vcp_update u_update (
      .req        (in_req_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.volume_level <= VOL_RESET;
         state_ff.mute_flag    <= 1'b0;
         state_ff.change_count <= '0;
         state_ff.flag_byte    <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_rsp_ff.status;
   assign rsp_volume_now   = out_rsp_ff.volume_now;
   assign rsp_mute_now     = out_rsp_ff.mute_now;
   assign rsp_counter_now  = out_rsp_ff.counter_now;
   assign rsp_flags_now    = out_rsp_ff.flags_now;
   assign rsp_flags_notify = out_rsp_ff.flags_notify;
   assign rsp_state_notify = out_rsp_ff.state_notify;

endmodule

// ===== rtl/vcp_checker.sv =====
module vcp_checker import vcp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [BYTE_W-1:0] rsp_counter_now,
   input logic [BYTE_W-1:0] rsp_flags_now,
   input logic              rsp_flags_notify,
   input logic              rsp_state_notify
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_counter_now))
      else $error("result changed while stalled");

   // failed writes never notify
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_state_notify && !rsp_flags_notify)
      else $error("notify pulse on a failed write");

   // flags notification only after flags were set to persisted
   a_flags_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flags_notify |-> rsp_flags_now == FLAG_PERSISTED &&
                                        rsp_status == ST_OK)
      else $error("flags notify with wrong flags value");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind volume_control_point vcp_checker u_vcp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_counter_now  (rsp_counter_now),
   .rsp_flags_now    (rsp_flags_now),
   .rsp_flags_notify (rsp_flags_notify),
   .rsp_state_notify (rsp_state_notify)
);
